>>> sv/sfrw_pkg.sv
// Package with types, constants and the band table of the synthesizer register sequencer.
package sfrw_pkg;

    localparam int unsigned XTAL_HZ    = 25000000;
    localparam int unsigned DEN_C      = 20'hFFFFF;
    localparam int unsigned F_MIN      = 1500;
    localparam int unsigned F_MAX      = 280000000;
    localparam int unsigned DIV_W      = 11;
    localparam int unsigned VCO_W      = 31;
    localparam int unsigned QUO_W      = 13;
    localparam int unsigned FRAC_W     = 20;
    // The crystal frequency is 2^6 times an odd factor; division by the odd
    // factor uses a 32 bit reciprocal scaled by 2^50.
    localparam int unsigned XTAL_SH    = 6;
    localparam int unsigned XTAL_ODD   = 390625;
    localparam int unsigned ODD_W      = 19;
    localparam int unsigned NUM_W      = 31;
    localparam int unsigned XTAL_RECIP = 32'd2882303762;
    localparam int unsigned RECIP_SH   = 50;

    typedef struct packed {
        logic        operation;
        logic [31:0] freq_hz;
        logic        enable;
        logic        force_pll_reset;
    } t_req;

    typedef struct packed {
        logic [7:0] reg_addr;
        logic [7:0] reg_data;
        logic       last;
    } t_wr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VCO,
        ST_DIVA,
        ST_WAITA,
        ST_WAITH,
        ST_WAITL,
        ST_EMIT
    } t_state;

    function automatic logic [DIV_W+2:0] band(input logic [31:0] f);
        logic [DIV_W-1:0] m;
        logic [2:0]       r;
        begin
            r = 3'd0;
            if (f > 32'd150000000)      m = 11'd4;
            else if (f >= 32'd63000000) m = 11'd6;
            else if (f >= 32'd27500000) m = 11'd14;
            else if (f >= 32'd13000000) m = 11'd30;
            else if (f >= 32'd6500000)  m = 11'd62;
            else if (f >= 32'd3000000)  m = 11'd126;
            else if (f >= 32'd1500000)  m = 11'd280;
            else if (f >= 32'd700000)   m = 11'd600;
            else if (f >= 32'd330000)   m = 11'd1280;
            else if (f >= 32'd150000) begin m = 11'd1300; r = 3'd1; end
            else if (f >= 32'd67000) begin  m = 11'd1500; r = 3'd2; end
            else if (f >= 32'd30300) begin  m = 11'd1600; r = 3'd3; end
            else if (f >= 32'd14000) begin  m = 11'd1800; r = 3'd4; end
            else if (f >= 32'd7000) begin   m = 11'd1800; r = 3'd5; end
            else if (f >= 32'd3500) begin   m = 11'd1800; r = 3'd6; end
            else begin                      m = 11'd1800; r = 3'd7; end
            band = {m, r};
        end
    endfunction

endpackage

>>> sv/synth_freq_to_register_writes.sv
// Top level of the frequency to synthesizer register write sequencer.
// A request names a channel (carrier on PLL A with outputs 0 and 1, or tuning
// on PLL B with output 2) and a frequency, which is clamped to 1500 Hz up to
// 280 MHz. The block picks the output dividers from a band table, forms the
// VCO frequency with one multiply, and splits it against the 25 MHz crystal
// with three passes through one shared reciprocal divider by the odd factor
// 390625 of the crystal (the factor 64 is a shift). The first pass gives the
// integer part a and the VCO remainder; the next two give
// floor(remainder * 2^20 / 25 MHz) in two digits, and one compare turns that
// into b = floor(remainder * 0xFFFFF / 25 MHz). The packed PLL words follow
// from shifts, adds, subtracts and one multiply by 0xFFFFF. It then emits the
// byte writes one per cycle while the output is not stalled, 28 or 29 for an
// enabled carrier request, 2 for a disabled one, 16 or 17 for tuning, with
// last set on the final write. An enabled request passes through the states
// VCO, DIVA, WAITA, WAITH, WAITL and EMIT; a disabled carrier request goes
// straight to EMIT. The input is stalled from acceptance until the last write
// has been taken by the downstream side.
module synth_freq_to_register_writes import sfrw_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_stall,
    output t_wr  o_wr
);
    t_state r_state, n_state;
    t_req   r_req;
    logic [31:0]       r_f;
    logic [DIV_W-1:0]  r_m;
    logic [2:0]        r_r;
    logic [VCO_W-1:0]  r_vco;
    logic [QUO_W-1:0]  r_a;
    logic [24:0]       r_rema;
    logic [QUO_W-1:0]  r_qhi;
    logic [FRAC_W-1:0] r_b;
    logic [DIV_W-1:0]  r_last_car, r_last_tun;
    logic              r_doreset;
    logic [4:0]        r_idx;
    logic [4:0]        w_cnt;
    logic              w_div_start;
    logic [NUM_W-1:0]  w_div_num;
    logic              w_div_done;
    logic [QUO_W-1:0]  w_quo;
    logic [ODD_W-1:0]  w_rem;
    logic [24:0]       w_rema;
    logic [FRAC_W-1:0] w_q1;
    logic [42:0]       w_prod;
    logic [VCO_W-1:0]  w_vco;
    logic [31:0]       w_fc;
    logic [DIV_W+2:0]  w_band;
    logic [31:0]       w_p1, w_p2, w_ms1;
    logic [6:0]        w_dd;
    logic [FRAC_W+7:0] w_b128;
    logic [7:0]        w_ctl, w_base;
    logic [7:0]        w_addr, w_data;
    logic              w_accept, w_out_take;

    assign w_fc = (i_req.freq_hz < F_MIN) ? F_MIN :
                  (i_req.freq_hz > F_MAX) ? F_MAX : i_req.freq_hz;
    assign w_band   = band(w_fc);
    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign w_out_take = o_valid && !i_stall;

    // The VCO frequency stays below 2^31 in every band.
    assign w_prod = 43'(r_f) * 43'(r_m);
    assign w_vco  = VCO_W'(w_prod << r_r);

    // The VCO remainder against the crystal is the odd-factor remainder
    // with the six low VCO bits appended.
    assign w_rema = {w_rem, r_vco[XTAL_SH-1:0]};
    assign w_q1   = {r_qhi[11:0], w_quo[7:0]};

    // Pass one divides VCO/64. Pass two divides remainder*64, pass three the
    // second remainder*256, so together they give remainder*2^14/390625.
    assign w_div_start = (r_state == ST_DIVA) ||
                         ((r_state == ST_WAITA || r_state == ST_WAITH) && w_div_done);
    always_comb begin
        case (r_state)
            ST_WAITA: w_div_num = NUM_W'({w_rema, 6'd0});
            ST_WAITH: w_div_num = NUM_W'({w_rem, 8'd0});
            default:  w_div_num = NUM_W'(r_vco >> XTAL_SH);
        endcase
    end

    sfrw_div #(.N_W(NUM_W), .Q_W(QUO_W), .R_W(ODD_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .o_done  (w_div_done),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // dd = floor(128*b/c): b < c, so dd < 128 and a short compare chain is
    // replaced by floor((128b + floor(128b/2^20) + 1) / 2^20), exact for c = 2^20-1.
    assign w_b128 = {1'b0, r_b, 7'd0};
    assign w_dd   = 7'((w_b128 + (w_b128 >> 20) + 1'b1) >> 20);
    assign w_p1   = 32'({r_a, 7'd0}) + 32'(w_dd) - 32'd512;
    assign w_p2   = 32'(w_b128) - 32'(DEN_C) * 32'(w_dd);
    assign w_ms1  = 32'({r_m, 7'd0}) - 32'd512;
    assign w_ctl  = (r_m == DIV_W'(4)) ? 8'h0C :
                    ({1'b0, r_r, 4'd0} & 8'h70) | {6'd0, w_ms1[17:16]};

    always_comb begin
        if (!r_req.operation && !r_req.enable) w_cnt = 5'd2;
        else if (!r_req.operation)             w_cnt = r_doreset ? 5'd29 : 5'd28;
        else                                   w_cnt = r_doreset ? 5'd17 : 5'd16;
    end

    // Write list: one position per output write.
    always_comb begin
        logic [4:0] k;
        logic [2:0] j;
        w_addr = 8'd0;
        w_data = 8'd0;
        w_base = 8'd0;
        k = r_idx;
        j = 3'd0;
        if (!r_req.operation && !r_req.enable) begin
            w_addr = (r_idx == 5'd0) ? 8'd16 : 8'd17;
            w_data = 8'h80;
        end else begin
            if (!r_req.operation) begin
                if (r_idx < 5'd2) begin
                    w_addr = (r_idx == 5'd0) ? 8'd16 : 8'd17;
                    w_data = 8'h4F;
                end
                k = r_idx - 5'd2;
            end
            if ((!r_req.operation && r_idx >= 5'd2) || r_req.operation) begin
                j = k[2:0];
                if (k < 5'd8) begin
                    w_base = r_req.operation ? 8'd34 : 8'd26;
                    w_addr = w_base + {5'd0, j};
                    case (j)
                        3'd0:    w_data = 8'hFF;
                        3'd1:    w_data = 8'hFF;
                        3'd2:    w_data = {6'd0, w_p1[17:16]};
                        3'd3:    w_data = w_p1[15:8];
                        3'd4:    w_data = w_p1[7:0];
                        3'd5:    w_data = 8'hF0 | {4'd0, w_p2[19:16]};
                        3'd6:    w_data = w_p2[15:8];
                        default: w_data = w_p2[7:0];
                    endcase
                end else if (k < 5'd24 && !(r_req.operation && k >= 5'd16)) begin
                    w_base = r_req.operation ? 8'd58 : ((k < 5'd16) ? 8'd42 : 8'd50);
                    w_addr = w_base + {5'd0, j};
                    case (j)
                        3'd1:    w_data = 8'd1;
                        3'd2:    w_data = w_ctl;
                        3'd3:    w_data = (r_m == DIV_W'(4)) ? 8'd0 : w_ms1[15:8];
                        3'd4:    w_data = (r_m == DIV_W'(4)) ? 8'd0 : w_ms1[7:0];
                        default: w_data = 8'd0;
                    endcase
                end else if (!r_req.operation && k == 5'd24) begin
                    w_addr = 8'd165;
                end else if (!r_req.operation && k == 5'd25) begin
                    w_addr = 8'd166;
                    w_data = r_m[7:0];
                end else begin
                    w_addr = 8'd177;
                    w_data = r_req.operation ? 8'h80 : 8'h20;
                end
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept)
                    n_state = (!i_req.operation && !i_req.enable) ? ST_EMIT : ST_VCO;
            end
            ST_VCO:   n_state = ST_DIVA;
            ST_DIVA:  n_state = ST_WAITA;
            ST_WAITA: if (w_div_done) n_state = ST_WAITH;
            ST_WAITH: if (w_div_done) n_state = ST_WAITL;
            ST_WAITL: if (w_div_done) n_state = ST_EMIT;
            ST_EMIT:  if (w_out_take && r_idx == w_cnt - 5'd1) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_valid        = (r_state == ST_EMIT);
        o_wr.reg_addr  = w_addr;
        o_wr.reg_data  = w_data;
        o_wr.last      = (r_idx == w_cnt - 5'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= 5'd0;
            r_last_car <= '0;
            r_last_tun <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE) r_idx <= 5'd0;
            else if (w_out_take)    r_idx <= r_idx + 5'd1;
            if (r_state == ST_VCO) begin
                if (r_req.operation) r_last_tun <= r_m;
                else                 r_last_car <= r_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
            r_f   <= w_fc;
            r_m   <= w_band[DIV_W+2:3];
            r_r   <= w_band[2:0];
            r_doreset <= i_req.operation ? (r_last_tun != w_band[DIV_W+2:3]) :
                         ((r_last_car != w_band[DIV_W+2:3]) || i_req.force_pll_reset);
        end
        if (r_state == ST_VCO) r_vco <= w_vco;
        if (r_state == ST_WAITA && w_div_done) begin
            r_a    <= w_quo;
            r_rema <= w_rema;
        end
        if (r_state == ST_WAITH && w_div_done) r_qhi <= w_quo;
        // The remainder times 0xFFFFF falls one below the 2^20 quotient when
        // the scaled remainder is smaller than the VCO remainder.
        if (r_state == ST_WAITL && w_div_done)
            r_b <= w_q1 - FRAC_W'({w_rem, 6'd0} < r_rema);
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_stall)
        else $error("request taken while busy");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx < w_cnt))
        else $error("write index past end");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_take && o_wr.last) |=> (r_state == ST_IDLE))
        else $error("sequencer did not finish after last write");
`endif
endmodule

>>> sv/sfrw_div.sv
// Reciprocal divider by the odd crystal factor: the quotient is registered at start, the remainder after it.
module sfrw_div import sfrw_pkg::*; #(
    parameter int unsigned N_W = NUM_W,
    parameter int unsigned Q_W = QUO_W,
    parameter int unsigned R_W = ODD_W
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_num,
    output logic           o_done,
    output logic [Q_W-1:0] o_quo,
    output logic [R_W-1:0] o_rem
);
    localparam int unsigned P_W = N_W + 32;

    logic [N_W-1:0] r_num;
    logic [Q_W-1:0] r_quo;
    logic [R_W-1:0] r_rem;
    logic [1:0]     r_stage;
    logic [P_W-1:0] w_prod;
    logic [N_W-1:0] w_back;

    // The scaled reciprocal gives the exact quotient for any numerator below 2^31.
    assign w_prod = P_W'(i_num) * P_W'(XTAL_RECIP);
    assign w_back = N_W'(r_quo) * N_W'(XTAL_ODD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 2'b00;
        end else begin
            r_stage <= {r_stage[0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_quo <= w_prod[RECIP_SH +: Q_W];
        end
        if (r_stage[0]) r_rem <= R_W'(r_num - w_back);
    end

    assign o_done = r_stage[1];
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

>>> tb/synth_freq_to_register_writes_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the register writes of each request and compares them.
module synth_freq_to_register_writes_checker import sfrw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_req,
    input  t_req        i_req,
    input  logic        i_wr_valid,
    input  logic        i_wr_stall,
    input  t_wr         i_wr,
    output int unsigned o_errors,
    output int unsigned o_pending
);

    localparam logic [7:0] REG_OE0      = 8'd16;
    localparam logic [7:0] REG_OE1      = 8'd17;
    localparam logic [7:0] REG_PLLA     = 8'd26;
    localparam logic [7:0] REG_PLLB     = 8'd34;
    localparam logic [7:0] REG_MS0      = 8'd42;
    localparam logic [7:0] REG_MS1      = 8'd50;
    localparam logic [7:0] REG_MS2      = 8'd58;
    localparam logic [7:0] REG_PHASE    = 8'd165;
    localparam logic [7:0] REG_PHASE1   = 8'd166;
    localparam logic [7:0] REG_PLLRST   = 8'd177;
    localparam logic [7:0] OE_ON        = 8'h4F;
    localparam logic [7:0] OE_OFF       = 8'h80;
    localparam logic [7:0] RST_A        = 8'h20;
    localparam logic [7:0] RST_B        = 8'h80;
    localparam logic [7:0] CTL_DIV4     = 8'h0C;

    t_wr            write_queue[$];
    logic [10:0]    carrier_div;
    logic [10:0]    tuning_div;
    int unsigned    errors;

    assign o_errors  = errors;
    assign o_pending = write_queue.size();

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic push_write(input logic [7:0] addr, input logic [7:0] data);
        t_wr w;
        w.reg_addr = addr;
        w.reg_data = data;
        w.last     = 1'b0;
        write_queue.push_back(w);
    endtask

    task automatic pick_dividers(input logic [31:0] f, output logic [10:0] m,
                                 output logic [2:0] r);
        r = 3'd0;
        if (f > 32'd150000000)      m = 11'd4;
        else if (f >= 32'd63000000) m = 11'd6;
        else if (f >= 32'd27500000) m = 11'd14;
        else if (f >= 32'd13000000) m = 11'd30;
        else if (f >= 32'd6500000)  m = 11'd62;
        else if (f >= 32'd3000000)  m = 11'd126;
        else if (f >= 32'd1500000)  m = 11'd280;
        else if (f >= 32'd700000)   m = 11'd600;
        else if (f >= 32'd330000)   m = 11'd1280;
        else if (f >= 32'd150000) begin m = 11'd1300; r = 3'd1; end
        else if (f >= 32'd67000) begin  m = 11'd1500; r = 3'd2; end
        else if (f >= 32'd30300) begin  m = 11'd1600; r = 3'd3; end
        else if (f >= 32'd14000) begin  m = 11'd1800; r = 3'd4; end
        else if (f >= 32'd7000) begin   m = 11'd1800; r = 3'd5; end
        else if (f >= 32'd3500) begin   m = 11'd1800; r = 3'd6; end
        else begin                      m = 11'd1800; r = 3'd7; end
    endtask

    task automatic push_pll(input logic [7:0] base, input logic [31:0] f,
                            input logic [10:0] m, input logic [2:0] r);
        logic [63:0] vco, a, b, dd, p1, p2, p3;
        vco = (64'(f) * 64'(m)) << r;
        a   = vco / 64'd25000000;
        b   = ((vco - a * 64'd25000000) * 64'hFFFFF) / 64'd25000000;
        dd  = (64'd128 * b) / 64'hFFFFF;
        p1  = (64'd128 * a + dd - 64'd512) & 64'hFFFFFFFF;
        p2  = (64'd128 * b - 64'hFFFFF * dd) & 64'hFFFFFFFF;
        p3  = 64'hFFFFF;
        push_write(base + 8'd0, 8'(p3 >> 8));
        push_write(base + 8'd1, 8'(p3));
        push_write(base + 8'd2, 8'((p1 >> 16) & 64'h3));
        push_write(base + 8'd3, 8'(p1 >> 8));
        push_write(base + 8'd4, 8'(p1));
        push_write(base + 8'd5, 8'(((p3 >> 12) & 64'hF0) | ((p2 >> 16) & 64'h0F)));
        push_write(base + 8'd6, 8'(p2 >> 8));
        push_write(base + 8'd7, 8'(p2));
    endtask

    task automatic push_multisynth(input logic [7:0] base, input logic [10:0] m,
                                   input logic [2:0] r);
        logic [31:0] p1;
        logic [7:0]  ctl;
        p1 = 32'd0;
        if (m == 11'd4) begin
            ctl = CTL_DIV4;
        end else begin
            p1  = 32'd128 * 32'(m) - 32'd512;
            ctl = ({5'd0, r} << 4) & 8'h70 | 8'((p1 >> 16) & 32'h3);
        end
        push_write(base + 8'd0, 8'd0);
        push_write(base + 8'd1, 8'd1);
        push_write(base + 8'd2, ctl);
        push_write(base + 8'd3, p1[15:8]);
        push_write(base + 8'd4, p1[7:0]);
        push_write(base + 8'd5, 8'd0);
        push_write(base + 8'd6, 8'd0);
        push_write(base + 8'd7, 8'd0);
    endtask

    task automatic predict_writes(input t_req q);
        logic [31:0] f;
        logic [10:0] m;
        logic [2:0]  r;
        f = q.freq_hz;
        if (f < 32'd1500) f = 32'd1500;
        else if (f > 32'd280000000) f = 32'd280000000;
        if (q.operation == 1'b0) begin
            if (q.enable) begin
                push_write(REG_OE0, OE_ON);
                push_write(REG_OE1, OE_ON);
                pick_dividers(f, m, r);
                push_pll(REG_PLLA, f, m, r);
                push_multisynth(REG_MS0, m, r);
                push_multisynth(REG_MS1, m, r);
                push_write(REG_PHASE, 8'd0);
                push_write(REG_PHASE1, m[7:0]);
                if (carrier_div != m || q.force_pll_reset) push_write(REG_PLLRST, RST_A);
                carrier_div = m;
            end else begin
                push_write(REG_OE0, OE_OFF);
                push_write(REG_OE1, OE_OFF);
            end
        end else begin
            pick_dividers(f, m, r);
            push_pll(REG_PLLB, f, m, r);
            push_multisynth(REG_MS2, m, r);
            if (tuning_div != m) push_write(REG_PLLRST, RST_B);
            tuning_div = m;
        end
        write_queue[write_queue.size() - 1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_wr e;
        if (!i_rst_n) begin
            carrier_div = '0;
            tuning_div  = '0;
            errors      = 0;
            write_queue.delete();
        end else begin
            if (i_wr_valid && !i_wr_stall) begin
                if (write_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected write %0d=%02h", i_wr.reg_addr,
                                              i_wr.reg_data));
                end else begin
                    e = write_queue.pop_front();
                    if (i_wr.reg_addr !== e.reg_addr)
                        report_mismatch($sformatf("addr %0d, want %0d", i_wr.reg_addr,
                                                  e.reg_addr));
                    if (i_wr.reg_data !== e.reg_data)
                        report_mismatch($sformatf("data %02h at %0d, want %02h",
                                                  i_wr.reg_data, e.reg_addr, e.reg_data));
                    if (i_wr.last !== e.last)
                        report_mismatch($sformatf("last %b at %0d, want %b", i_wr.last,
                                                  e.reg_addr, e.last));
                end
            end
            if (i_valid && !i_stall_req) predict_writes(i_req);
        end
    end

endmodule

>>> tb/synth_freq_to_register_writes_tb.sv
`timescale 1ns / 1ps
// Top of the testbench: drives requests and stalls and gives the verdict.
module synth_freq_to_register_writes_tb;
    import sfrw_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    t_req        req;
    logic        wr_valid;
    logic        wr_stall;
    t_wr         wr;
    int unsigned errors;
    int unsigned pending;

    // Knobs shared between the request driver and the stall process.
    bit          quiet_phase;   // No idling on either side while set.
    bit          hold_writes;   // Receiver holds off for a long stretch.

    synth_freq_to_register_writes i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (req_valid),
        .o_stall (req_stall),
        .i_req   (req),
        .o_valid (wr_valid),
        .i_stall (wr_stall),
        .o_wr    (wr)
    );

    synth_freq_to_register_writes_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (req_valid),
        .i_stall_req (req_stall),
        .i_req       (req),
        .i_wr_valid  (wr_valid),
        .i_wr_stall  (wr_stall),
        .i_wr        (wr),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stall: about 15 percent at random, none in the quiet phase, and
    // solid while a long hold-off is in progress.
    always @(posedge clk) begin
        if (!rst_n) begin
            wr_stall <= 1'b0;
        end else if (hold_writes) begin
            wr_stall <= 1'b1;
        end else if (quiet_phase) begin
            wr_stall <= 1'b0;
        end else begin
            wr_stall <= ($urandom_range(99) < 15);
        end
    end

    // Offers one request and holds it, unchanged, until the block takes it.
    // The idle gap is inserted before raising valid, so valid never drops
    // and rises again within one step.
    task automatic send_request(input t_req q);
        if (!quiet_phase) begin
            while ($urandom_range(99) < 15) begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        req       <= q;
        @(posedge clk);
        while (req_stall) @(posedge clk);
    endtask

    task automatic idle_until_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic t_req make_request(input logic op, input logic [31:0] f,
                                          input logic en, input logic frc);
        t_req q;
        q.operation       = op;
        q.freq_hz         = f;
        q.enable          = en;
        q.force_pll_reset = frc;
        return q;
    endfunction

    // Picks a frequency from a spread that covers every band, several band edges,
    // both clamps and the full 32-bit range.
    function automatic logic [31:0] random_freq();
        logic [31:0] edges [17] = '{0, 1499, 1500, 3499, 3500, 6999, 7000, 30299,
                                    150000, 699999, 1500000, 6500000, 63000000,
                                    150000000, 150000001, 280000000, 280000001};
        case ($urandom_range(4))
            0: return edges[$urandom_range(16)];
            1: return $urandom();
            2: return $urandom_range(150000, 1500);
            3: return $urandom_range(30000000, 150000);
            default: return $urandom_range(280000000, 30000000);
        endcase
    endfunction

    initial begin
        t_req q;
        logic [31:0] f;
        req_valid   <= 1'b0;
        req         <= '0;
        quiet_phase = 1'b0;
        hold_writes = 1'b0;
        rst_n       <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: clamps, band edges, both channels, disable, forced reset,
        // divide-by-four band, and a repeated divider with no PLL reset.
        send_request(make_request(1'b0, 32'd0, 1'b1, 1'b0));
        send_request(make_request(1'b0, 32'hFFFFFFFF, 1'b1, 1'b0));
        send_request(make_request(1'b0, 32'd280000000, 1'b1, 1'b0));
        send_request(make_request(1'b0, 32'd200000000, 1'b1, 1'b1));
        send_request(make_request(1'b0, 32'd150000000, 1'b1, 1'b0));
        send_request(make_request(1'b0, 32'd7000000, 1'b0, 1'b1));
        send_request(make_request(1'b0, 32'd7100000, 1'b1, 1'b0));
        send_request(make_request(1'b1, 32'd0, 1'b0, 1'b0));
        send_request(make_request(1'b1, 32'd1500, 1'b1, 1'b1));
        send_request(make_request(1'b1, 32'hFFFFFFFF, 1'b0, 1'b0));
        send_request(make_request(1'b1, 32'd280000000, 1'b0, 1'b0));
        send_request(make_request(1'b1, 32'd150000001, 1'b0, 1'b0));
        send_request(make_request(1'b1, 32'd63000000, 1'b0, 1'b0));
        send_request(make_request(1'b1, 32'd27500000, 1'b1, 1'b0));
        send_request(make_request(1'b1, 32'd13000000, 1'b0, 1'b0));
        send_request(make_request(1'b1, 32'd3000000, 1'b0, 1'b0));
        send_request(make_request(1'b1, 32'd330000, 1'b0, 1'b0));
        send_request(make_request(1'b1, 32'd67000, 1'b0, 1'b0));
        send_request(make_request(1'b1, 32'd14000, 1'b0, 1'b0));
        send_request(make_request(1'b0, 32'd3500, 1'b1, 1'b0));
        send_request(make_request(1'b0, 32'd1499, 1'b1, 1'b0));
        send_request(make_request(1'b0, 32'hAAAAAAAA, 1'b0, 1'b0));
        send_request(make_request(1'b0, 32'h55555555, 1'b1, 1'b1));

        // The sender pauses until every write of the directed part is out.
        idle_until_drained();

        // The receiver holds off for a long stretch while requests keep
        // coming, so the block fills up and stalls its input.
        fork
            begin
                hold_writes = 1'b1;
                repeat (300) @(posedge clk);
                hold_writes = 1'b0;
            end
            begin
                repeat (3) send_request(make_request(1'(($urandom_range(1))),
                                        random_freq(), 1'b1, 1'(($urandom_range(1)))));
            end
        join

        for (int n = 0; n < 200; n++) begin
            quiet_phase = (n >= 80 && n < 110);
            f = random_freq();
            // Repeat a frequency now and then so the unchanged-divider path
            // without a PLL reset is exercised on both channels.
            if ($urandom_range(5) == 0) f = 32'd10000000;
            q = make_request(1'($urandom_range(1)), f, ($urandom_range(9) != 0),
                             1'($urandom_range(1)));
            send_request(q);
            if (n == 150) idle_until_drained();
        end
        quiet_phase = 1'b0;
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // About 230 requests, with stalls, fit well
    // inside this limit.
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

endmodule
